@@ rtl/core/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants, font tables and the byte classifier for the
// character to LED matrix scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int COLUMNS    = 8;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int GLYPH_W    = 6;
    localparam int DIGITS     = 10;
    localparam int LETTERS    = 26;
    localparam int GLYPHS     = DIGITS + LETTERS;

    localparam logic [7:0] ASCII_0       = 8'd48;
    localparam logic [7:0] ASCII_9       = 8'd57;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [7:0] ROW_ALL_OFF   = 8'hFF;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] char_byte;
    } t_item;

    typedef struct packed {
        logic               printable;
        logic [GLYPH_W-1:0] glyph;
    } t_class;

    // Digit glyphs, eight columns per glyph.
    localparam logic [7:0] DIGIT_ROM [DIGITS*COLUMNS] = '{
        8'hFF,8'hC1,8'h80,8'hAE,8'hB6,8'h80,8'hC1,8'hFF,
        8'hFF,8'hFE,8'hEE,8'h80,8'h80,8'hFE,8'hFE,8'hFF,
        8'hFF,8'hDC,8'h98,8'hBA,8'hB6,8'h86,8'hCE,8'hFF,
        8'hFF,8'hDD,8'h9C,8'hB6,8'hB6,8'h80,8'hC9,8'hFF,
        8'hFF,8'hF3,8'hEB,8'hDB,8'h80,8'h80,8'hFB,8'hFF,
        8'hFF,8'h8D,8'h8C,8'hAE,8'hAE,8'hA0,8'hB1,8'hFF,
        8'hFF,8'hC1,8'h80,8'hB6,8'hB6,8'h90,8'hD9,8'hFF,
        8'hFF,8'h9F,8'h9F,8'hB8,8'hA0,8'h87,8'h9F,8'hFF,
        8'hFF,8'hC9,8'h80,8'hB6,8'hB6,8'h80,8'hC9,8'hFF,
        8'hFF,8'hCD,8'h84,8'hB6,8'hB6,8'h80,8'hC1,8'hFF
    };

    // Letter glyphs A through Z, eight columns per glyph.
    localparam logic [7:0] LETTER_ROM [LETTERS*COLUMNS] = '{
        8'hFF,8'hC0,8'h80,8'hB7,8'hB7,8'h80,8'hC0,8'hFF,
        8'hFF,8'h80,8'h80,8'hB6,8'hB6,8'h80,8'hC9,8'hFF,
        8'hFF,8'hC1,8'h80,8'hBE,8'hBE,8'h9C,8'hDD,8'hFF,
        8'hFF,8'h80,8'h80,8'hBE,8'hBE,8'h80,8'hC1,8'hFF,
        8'hFF,8'h80,8'h80,8'hB6,8'hB6,8'hBE,8'hBE,8'hFF,
        8'hFF,8'h80,8'h80,8'hB7,8'hB7,8'hBF,8'hBF,8'hFF,
        8'hFF,8'hC1,8'h80,8'hBE,8'hBA,8'h98,8'hD9,8'hFF,
        8'hFF,8'h80,8'h80,8'hF7,8'hF7,8'h80,8'h80,8'hFF,
        8'hFF,8'hFF,8'hBE,8'h80,8'h80,8'hBE,8'hFF,8'hFF,
        8'hFF,8'hF9,8'hF8,8'hBE,8'h80,8'h81,8'hBF,8'hFF,
        8'hFF,8'h80,8'h80,8'hE3,8'hC9,8'h9C,8'hBE,8'hFF,
        8'hFF,8'h80,8'h80,8'hFE,8'hFE,8'hFE,8'hFE,8'hFF,
        8'hFF,8'h80,8'h80,8'hCF,8'hE7,8'hCF,8'h80,8'h80,
        8'hFF,8'h80,8'h80,8'hCF,8'hE7,8'hF3,8'h80,8'h80,
        8'hFF,8'hC1,8'h80,8'hBE,8'hBE,8'h80,8'hC1,8'hFF,
        8'hFF,8'h80,8'h80,8'hBB,8'hBB,8'h83,8'hC7,8'hFF,
        8'hFF,8'hC3,8'h81,8'hBD,8'hBD,8'h80,8'hC2,8'hFF,
        8'hFF,8'h80,8'h80,8'hB3,8'hB1,8'h84,8'hCE,8'hFF,
        8'hFF,8'hCD,8'h84,8'hB6,8'hB6,8'h90,8'hD9,8'hFF,
        8'hFF,8'h9F,8'hBF,8'h80,8'h80,8'hBF,8'h9F,8'hFF,
        8'hFF,8'h81,8'h80,8'hFE,8'hFE,8'h80,8'h80,8'hFF,
        8'hFF,8'h83,8'h81,8'hFC,8'hFC,8'h81,8'h83,8'hFF,
        8'hFF,8'h80,8'h80,8'hF9,8'hF3,8'hF9,8'h80,8'h80,
        8'hFF,8'h9C,8'h88,8'hE3,8'hF7,8'hE3,8'h88,8'h9C,
        8'hFF,8'h8F,8'h87,8'hF0,8'hF0,8'h87,8'h8F,8'hFF,
        8'hFF,8'hBC,8'hB8,8'hB2,8'hA6,8'h8E,8'h9E,8'hFF
    };

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c.printable = 1'b0;
        c.glyph     = '0;
        if (b >= ASCII_0 && b <= ASCII_9) begin
            c.printable = 1'b1;
            c.glyph     = GLYPH_W'(b - ASCII_0);
        end else if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            c.printable = 1'b1;
            c.glyph     = GLYPH_W'(b - ASCII_UPPER_A + 8'(DIGITS));
        end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
            c.printable = 1'b1;
            c.glyph     = GLYPH_W'(b - ASCII_LOWER_A + 8'(DIGITS));
        end
        return c;
    endfunction

    function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] glyph,
                                            input logic [COL_W-1:0]   col);
        logic [GLYPH_W-1:0] letter;
        logic [7:0]         row;
        letter = glyph - GLYPH_W'(DIGITS);
        if (glyph < GLYPH_W'(DIGITS)) begin
            row = DIGIT_ROM[{glyph[3:0], col}];
        end else if (glyph < GLYPH_W'(GLYPHS)) begin
            row = LETTER_ROM[{letter[4:0], col}];
        end else begin
            row = ROW_ALL_OFF;
        end
        return row;
    endfunction

endpackage

@@ rtl/core/char_to_led_matrix_scanner_core.sv @@
// ----------------------------------------------------------------------------
// char_to_led_matrix_scanner_core
// Character to 8x8 LED matrix scanner: bytes pick a glyph, ticks emit one column
// of the glyph as a row byte and a one-hot column select, or zeros when blank.
// ----------------------------------------------------------------------------
// A tick request passes the input register, then the result register.
// Throughput: one request per cycle; only a stalled result register holds
// back tick requests.
// Reset: synchronous, active low; display blank, no pending byte, column 0.
module char_to_led_matrix_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_byte
    input  logic        i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] row_pattern, [15:8] column_select
);

    ccs_pkg::t_item in_item;
    ccs_pkg::t_item held_item;
    logic           held_valid;
    logic           take;
    logic [7:0]     row_pattern;
    logic [7:0]     column_select;

    assign in_item.cmd       = ccs_pkg::t_cmd'(i_s_axis_tuser);
    assign in_item.char_byte = i_s_axis_tdata;

    ccs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_item  (in_item),
        .i_take  (take),
        .o_ready (o_s_axis_tready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    ccs_scan_ctrl u_scan_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (held_valid),
        .i_item          (held_item),
        .o_take          (take),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_row_pattern   (row_pattern),
        .o_column_select (column_select)
    );

    assign o_m_axis_tdata = {column_select, row_pattern};

endmodule

@@ rtl/core/ccs_in_stage.sv @@
// ----------------------------------------------------------------------------
// ccs_in_stage
// Input register: captures one request and holds it until the scan
// controller takes it.
// ----------------------------------------------------------------------------
module ccs_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ccs_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_valid,
    output ccs_pkg::t_item o_item
);

    logic           r_valid;
    ccs_pkg::t_item r_item;

    // Refill in the same cycle the held request drains.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/ccs_scan_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccs_scan_ctrl
// Display state, pending byte, column counter, font lookup and the
// result register.
// ----------------------------------------------------------------------------
module ccs_scan_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ccs_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_row_pattern,
    output logic [7:0]     o_column_select
);

    logic                         r_showing;
    logic [ccs_pkg::GLYPH_W-1:0]  r_glyph;
    logic [ccs_pkg::COL_W-1:0]    r_col;
    logic                         r_pend;
    logic                         r_pend_print;
    logic [ccs_pkg::GLYPH_W-1:0]  r_pend_glyph;
    logic                         r_out_valid;
    logic [7:0]                   r_row;
    logic [7:0]                   r_sel;

    logic                         n_showing;
    logic [ccs_pkg::GLYPH_W-1:0]  n_glyph;
    logic [ccs_pkg::COL_W-1:0]    n_col;
    logic                         n_pend;
    logic                         n_pend_print;
    logic [ccs_pkg::GLYPH_W-1:0]  n_pend_glyph;
    logic [7:0]                   n_row;
    logic [7:0]                   n_sel;

    logic                         out_free;
    logic                         is_tick;
    ccs_pkg::t_class              cls;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_tick  = (i_item.cmd == ccs_pkg::CMD_TICK);
    // A character request makes no result, so it never waits on the output.
    assign o_take   = i_valid && (!is_tick || out_free);
    assign cls      = ccs_pkg::classify(i_item.char_byte);

    always_comb begin
        n_showing    = r_showing;
        n_glyph      = r_glyph;
        n_col        = r_col;
        n_pend       = r_pend;
        n_pend_print = r_pend_print;
        n_pend_glyph = r_pend_glyph;
        n_row        = 8'h00;
        n_sel        = 8'h00;
        if (!is_tick) begin
            if (r_showing) begin
                n_pend       = 1'b1;
                n_pend_print = cls.printable;
                n_pend_glyph = cls.glyph;
            end else if (cls.printable) begin
                n_showing = 1'b1;
                n_glyph   = cls.glyph;
                n_col     = '0;
            end
        end else if (!r_showing) begin
            n_col = '0;
        end else begin
            n_row = ccs_pkg::font_row(r_glyph, r_col);
            n_sel = 8'(1) << r_col;
            if (r_col == ccs_pkg::COL_W'(ccs_pkg::COLUMNS - 1)) begin
                n_col = '0;
                // The frame ends here, so a waiting byte takes over.
                if (r_pend) begin
                    n_showing    = r_pend_print;
                    n_glyph      = r_pend_print ? r_pend_glyph : '0;
                    n_pend       = 1'b0;
                    n_pend_print = 1'b0;
                    n_pend_glyph = '0;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_showing    <= 1'b0;
            r_glyph      <= '0;
            r_col        <= '0;
            r_pend       <= 1'b0;
            r_pend_print <= 1'b0;
            r_pend_glyph <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_showing    <= n_showing;
                r_glyph      <= n_glyph;
                r_col        <= n_col;
                r_pend       <= n_pend;
                r_pend_print <= n_pend_print;
                r_pend_glyph <= n_pend_glyph;
            end
            if (out_free) begin
                r_out_valid <= o_take && is_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && is_tick) begin
            r_row <= n_row;
            r_sel <= n_sel;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_row_pattern   = r_row;
    assign o_column_select = r_sel;

endmodule
